// File: rtl/tfs_pkg.sv
// Package for the top-five selector: sizes, item and control types.
// No dependencies; every other file imports it.
package tfs_pkg;

  // List depth and value width
  localparam int TOP_COUNT  = 5;
  localparam int VALUE_BITS = 16;

  // Held count spans 0..TOP_COUNT, a slot index spans 0..TOP_COUNT-1
  localparam int COUNT_BITS = $clog2(TOP_COUNT + 1);
  localparam int IDX_BITS   = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int RANK_BITS  = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // What the back end does with an item
  typedef enum logic {
    KIND_INSERT,
    KIND_FLUSH
  } kind_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] score;
    kind_t                 kind;
  } item_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/tfs_if.sv
// Valid/ready channel interfaces for the selector input and result streams.
// Depends on tfs_pkg for field widths.
interface tfs_in_if import tfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] score;
  logic                  is_last;

  modport source (output valid, output score, output is_last, input ready);
  modport sink   (input valid, input score, input is_last, output ready);
endinterface

interface tfs_out_if import tfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] top_value;
  logic [RANK_BITS-1:0]  rank;
  logic                  last_of_run;

  modport source (output valid, output top_value, output rank, output last_of_run,
                  input ready);
  modport sink   (input valid, input top_value, input rank, input last_of_run,
                  output ready);
endinterface

// File: rtl/tfs_front.sv
// Front end: takes input transfers, tags each item as insert or flush and
// holds it in a short queue for the back end. Depends on tfs_pkg, tfs_if.
module tfs_front import tfs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  tfs_in_if.sink        in_ch,
  output q_head_t       head,
  input  logic          pop
);

  item_t                slots_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;
  logic                 push;
  logic                 do_pop;
  item_t                new_item;

  // Classify the incoming item
  always_comb begin
    new_item.score = in_ch.score;
    new_item.kind  = in_ch.is_last ? KIND_FLUSH : KIND_INSERT;
  end

  assign in_ch.ready = (cnt_r != QCNT_BITS'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = slots_r[rd_ptr_r];

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// File: rtl/tfs_back.sv
// Back end: sorted insertion into the ranking list and emission of the
// ranking on a flush item. Depends on tfs_pkg and tfs_if.
module tfs_back import tfs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  q_head_t       head,
  output logic          pop,
  tfs_out_if.source     out_ch
);

  logic [VALUE_BITS-1:0] vals_r   [TOP_COUNT];
  logic [VALUE_BITS-1:0] vals_nxt [TOP_COUNT];
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] idx_r, idx_nxt;
  state_t                state_r, state_nxt;

  logic                  ovalid_r, ovalid_nxt;
  logic [VALUE_BITS-1:0] ovalue_r, ovalue_nxt;
  logic [RANK_BITS-1:0]  orank_r, orank_nxt;
  logic                  olast_r, olast_nxt;

  logic [TOP_COUNT-1:0]  take;
  logic                  out_free;
  logic                  at_end;

  assign out_ch.valid       = ovalid_r;
  assign out_ch.top_value   = ovalue_r;
  assign out_ch.rank        = orank_r;
  assign out_ch.last_of_run = olast_r;

  assign out_free = !ovalid_r || out_ch.ready;
  assign at_end   = (idx_r + 1'b1 == count_r);

  // Slot i is taken over by the new value or its upper neighbour when it is
  // empty or holds a smaller value; ties stay above the new value
  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      take[i] = (COUNT_BITS'(i) >= count_r) || (vals_r[i] < head.item.score);
    end
  end

  // Next state, list update and output register load
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    vals_nxt   = vals_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ovalue_nxt = ovalue_r;
    orank_nxt  = orank_r;
    olast_nxt  = olast_r;
    pop        = 1'b0;

    unique case (state_r)
      ST_COLLECT: begin
        if (head.valid) begin
          pop = 1'b1;
          for (int i = 0; i < TOP_COUNT; i++) begin
            if (take[i]) begin
              if (i == 0) begin
                vals_nxt[i] = head.item.score;
              end else if (take[(i > 0) ? i - 1 : 0]) begin
                vals_nxt[i] = vals_r[(i > 0) ? i - 1 : 0];
              end else begin
                vals_nxt[i] = head.item.score;
              end
            end
          end
          if (count_r != COUNT_BITS'(TOP_COUNT)) begin
            count_nxt = count_r + 1'b1;
          end
          if (head.item.kind == KIND_FLUSH) begin
            idx_nxt   = '0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ovalue_nxt = vals_r[idx_r[IDX_BITS-1:0]];
          orank_nxt  = RANK_BITS'(idx_r);
          olast_nxt  = at_end;
          idx_nxt    = idx_r + 1'b1;
          if (at_end) begin
            count_nxt = '0;
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_COLLECT;
      count_r  <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers: list entries beyond the count are never read
  always_ff @(posedge clk) begin
    vals_r   <= vals_nxt;
    ovalue_r <= ovalue_nxt;
    orank_r  <= orank_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

// File: rtl/top_five_selector.sv
// Top-five selector: one input item per cycle while collecting; the queue
// stores each transferred item and hands it to the insertion stage.
// A flush item passes the queue and the list update, then the emit state
// sends one result per cycle (held count, 1..5) while the output register
// is free; intake stops once the two-entry queue is full. Reset (rst_n,
// synchronous, active low) empties queue, list and output register.
module top_five_selector import tfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tfs_in_if.sink    in_ch,
  tfs_out_if.source out_ch
);

  q_head_t head;
  logic    pop;

  tfs_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  tfs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: dv/tb_top_five_selector.sv
// Self-checking testbench for top_five_selector: streams sets of scores and
// checks each ranking entry against a predicted top-five list.
// Depends on rtl/tfs_pkg.sv, rtl/tfs_if.sv and rtl/top_five_selector.sv.
module tb_top_five_selector;
  import tfs_pkg::*;

  // One score on its way in
  typedef struct packed {
    logic [VALUE_BITS-1:0] score;
    logic                  closes_set;
  } score_item_t;

  // One ranking entry expected on the way out
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RANK_BITS-1:0]  rank;
    logic                  final_entry;
  } ranking_entry_t;

  // How the receiver stalls during one stretch
  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_PATTERN,
    DRAIN_SLOW
  } drain_mode_t;

  localparam int DIRECTED_ITEMS = 23;
  localparam int RANDOM_ITEMS   = 457;
  localparam int TAIL_CYCLES    = 20;

  logic clk;
  logic rst_n;

  tfs_in_if  in_ch ();
  tfs_out_if out_ch ();

  top_five_selector u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Stimulus and predicted results
  score_item_t           pending_scores[$];
  ranking_entry_t        expected_ranking[$];
  logic [VALUE_BITS-1:0] top_list[TOP_COUNT];
  int                    top_held;

  int items_total;
  int items_sent;
  int sets_closed;
  int entries_checked;
  int mismatches;

  // Sender pacing
  int burst_left;
  int gap_left;

  // Receiver pacing
  drain_mode_t drain_mode;
  int          drain_left;
  logic [31:0] drain_bits;

  // Clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic queue_score(input logic [VALUE_BITS-1:0] score, input logic closes_set);
    score_item_t it;
    it.score      = score;
    it.closes_set = closes_set;
    pending_scores.push_back(it);
    items_total++;
  endtask

  // Driver: predicts on each transfer, then presents the next score
  always @(posedge clk) begin : feed
    int             pos;
    score_item_t    nxt;
    ranking_entry_t ent;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        // insert after entries not smaller; drop when it falls off the end
        pos = 0;
        while (pos < top_held && top_list[pos] >= in_ch.score) pos++;
        if (pos < TOP_COUNT) begin
          for (int k = TOP_COUNT - 1; k > pos; k--) top_list[k] = top_list[k-1];
          top_list[pos] = in_ch.score;
          if (top_held < TOP_COUNT) top_held++;
        end
        if (in_ch.is_last) begin
          for (int k = 0; k < top_held; k++) begin
            ent.value       = top_list[k];
            ent.rank        = RANK_BITS'(k);
            ent.final_entry = (k == top_held - 1);
            expected_ranking.push_back(ent);
          end
          top_held = 0;
          sets_closed++;
        end
        items_sent++;
      end
      // hold while stalled, otherwise pick gap or next score
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0 || pending_scores.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          nxt = pending_scores.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.score   <= nxt.score;
          in_ch.is_last <= nxt.closes_set;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: ready follows a stall mode that is picked anew when its random stretch runs out
  always @(posedge clk) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 3));
      drain_left = $urandom_range(16, 96);
      drain_bits = $urandom;
    end
    drain_left--;
    case (drain_mode)
      DRAIN_FREE: out_ch.ready <= 1'b1;
      DRAIN_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
      DRAIN_PATTERN: begin
        out_ch.ready <= drain_bits[0];
        drain_bits = {drain_bits[0], drain_bits[31:1]};
      end
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Monitor: compare every transfer on the result side
  always @(posedge clk) begin : check
    ranking_entry_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      entries_checked++;
      if (expected_ranking.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected entry: value %0d rank %0d last %0b",
                   out_ch.top_value, out_ch.rank, out_ch.last_of_run);
      end else begin
        want = expected_ranking.pop_front();
        if (out_ch.top_value !== want.value || out_ch.rank !== want.rank ||
            out_ch.last_of_run !== want.final_entry) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %0d rank %0d last %0b, got %0d %0d %0b",
                     want.value, want.rank, want.final_entry,
                     out_ch.top_value, out_ch.rank, out_ch.last_of_run);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int                    set_len;
    int                    spread;
    logic [VALUE_BITS-1:0] v;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.score    = '0;
    in_ch.is_last  = 1'b0;
    out_ch.ready   = 1'b0;
    top_held       = 0;
    items_total    = 0;
    items_sent     = 0;
    sets_closed    = 0;
    entries_checked = 0;
    mismatches     = 0;
    burst_left     = 0;
    gap_left       = 0;
    drain_left     = 0;
    drain_mode     = DRAIN_FREE;
    drain_bits     = '0;

    // single-value sets at both extremes
    queue_score(16'd0, 1'b1);
    queue_score(16'hFFFF, 1'b1);
    // exactly five values with a duplicated maximum
    queue_score(16'd3, 1'b0);
    queue_score(16'hFFFF, 1'b0);
    queue_score(16'd0, 1'b0);
    queue_score(16'd100, 1'b0);
    queue_score(16'hFFFF, 1'b1);
    // overflow: smallest falls off, final value equals the smallest and is dropped
    queue_score(16'd10, 1'b0);
    queue_score(16'd20, 1'b0);
    queue_score(16'd30, 1'b0);
    queue_score(16'd40, 1'b0);
    queue_score(16'd50, 1'b0);
    queue_score(16'd60, 1'b0);
    queue_score(16'd20, 1'b1);
    // two values, alternating bit patterns
    queue_score(16'hAAAA, 1'b0);
    queue_score(16'h5555, 1'b1);
    // all equal
    queue_score(16'd7, 1'b0);
    queue_score(16'd7, 1'b0);
    queue_score(16'd7, 1'b1);
    // ascending, each new value goes to the head
    queue_score(16'd1, 1'b0);
    queue_score(16'd2, 1'b0);
    queue_score(16'd3, 1'b0);
    queue_score(16'hFFFE, 1'b1);

    // random sets, mostly short, some well past five values
    while (items_total < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      spread  = $urandom_range(0, 3);
      for (int i = 0; i < set_len; i++) begin
        case (spread)
          0: v = VALUE_BITS'($urandom_range(0, 16'hFFFF));
          1: v = VALUE_BITS'($urandom_range(0, 7));
          2: v = VALUE_BITS'($urandom_range(16'hFFF8, 16'hFFFF));
          default: begin
            case ($urandom_range(0, 3))
              0: v = '0;
              1: v = '1;
              default: v = VALUE_BITS'($urandom_range(0, 16'hFFFF));
            endcase
          end
        endcase
        queue_score(v, i == set_len - 1);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (items_sent < items_total) @(posedge clk);
    while (expected_ranking.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d sets from %0d scores; %0d ranking entries compared.",
             sets_closed, items_sent, entries_checked);
    $display("Mismatched or unexpected entries: %0d", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #800000;
    $display("Timeout: %0d of %0d scores sent, %0d entries outstanding",
             items_sent, items_total, expected_ranking.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tfs_pkg.sv
rtl/tfs_if.sv
rtl/tfs_front.sv
rtl/tfs_back.sv
rtl/top_five_selector.sv
dv/tb_top_five_selector.sv
